>>> design/signal_seeking_heading_steer_defines.svh
// Assertion macros used by the checker of this block.
`ifndef SIGNAL_SEEKING_HEADING_STEER_DEFINES_SVH
`define SIGNAL_SEEKING_HEADING_STEER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sshs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sshs assertion failed");

`endif

>>> design/sshs_pkg.sv
`default_nettype none

package sshs_pkg;

	localparam int HeadingW  = 9;
	localparam int SignalW   = 8;
	localparam int CmdW      = 2;
	localparam int SpeedW    = 10;
	localparam int ErrW      = 9;
	localparam int SpinW     = 10;
	localparam int PhaseW    = 2;
	localparam int DeadbandW = 7;
	localparam int StepLimW  = 8;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 10;

	localparam int InFieldsW  = HeadingW + SignalW;
	localparam int InTdataW   = ((InFieldsW + 7) / 8) * 8;
	localparam int OutFieldsW = CmdW + SpeedW + ErrW + SignalW + HeadingW + SpinW + PhaseW;
	localparam int OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

	// result field offsets in m_tdata
	localparam int OfsCmd    = 0;
	localparam int OfsSpeed  = OfsCmd + CmdW;
	localparam int OfsErr    = OfsSpeed + SpeedW;
	localparam int OfsBest   = OfsErr + ErrW;
	localparam int OfsTarget = OfsBest + SignalW;
	localparam int OfsSpin   = OfsTarget + HeadingW;
	localparam int OfsPhase  = OfsSpin + SpinW;

	localparam logic [CmdW-1:0] CMD_STOP    = 2'd0;
	localparam logic [CmdW-1:0] CMD_LEFT    = 2'd1;
	localparam logic [CmdW-1:0] CMD_RIGHT   = 2'd2;
	localparam logic [CmdW-1:0] CMD_FORWARD = 2'd3;

	localparam logic [PhaseW-1:0] PHASE_START = 2'd0;
	localparam logic [PhaseW-1:0] PHASE_SCAN  = 2'd1;
	localparam logic [PhaseW-1:0] PHASE_TRACK = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_DEADBAND    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SPIN_GOAL   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_STEP_LIMIT  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SCAN_SPEED  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_TRACK_SPEED = 3'd4;

	localparam logic [DeadbandW-1:0] DEADBAND_RST    = 7'd5;
	localparam logic [SpinW-1:0]     SPIN_GOAL_RST   = 10'd350;
	localparam logic [StepLimW-1:0]  STEP_LIMIT_RST  = 8'd45;
	localparam logic [SpeedW-1:0]    SCAN_SPEED_RST  = 10'd700;
	localparam logic [SpeedW-1:0]    TRACK_SPEED_RST = 10'd900;
	localparam logic [SignalW-1:0]   BEST_RST        = 8'h80;
	localparam logic [SpinW-1:0]     SPIN_MAX        = 10'd1023;

	typedef enum logic [2:0] {
		MODE_START = 3'b001,
		MODE_SCAN  = 3'b010,
		MODE_TRACK = 3'b100
	} mode_t;

	// reduce 0..1439 modulo 360
	function automatic logic [HeadingW-1:0] wrap360(input logic [10:0] v);
		logic [10:0] r;
		if (v >= 11'd1080) begin
			r = v - 11'd1080;
		end else if (v >= 11'd720) begin
			r = v - 11'd720;
		end else if (v >= 11'd360) begin
			r = v - 11'd360;
		end else begin
			r = v;
		end
		return r[HeadingW-1:0];
	endfunction

endpackage

`default_nettype wire

>>> design/signal_seeking_heading_steer.sv
// An accepted request is held in the input register, then its result in the result register on the master side.
// Throughput: one request per cycle unless m_tready stalls; the steering state updates in one pass.
// The input register and the result register each stall only on m_tready.
// Reset (arst_n low, asynchronous): both stages empty, state awaits start heading,
// best signal -128, configuration registers at their defaults.
`default_nettype none

module signal_seeking_heading_steer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// heading[8:0], signal_strength[16:9], zero fill
	input  logic [sshs_pkg::InTdataW-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// command[1:0], drive_speed[11:2], heading_error[20:12], best_signal[28:21],
	// target_heading[37:29], scan_progress[47:38], phase[49:48], zero fill
	output logic [sshs_pkg::OutTdataW-1:0]  m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sshs_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [sshs_pkg::CfgDataW-1:0]   cfg_data
);
	import sshs_pkg::*;

	logic [DeadbandW-1:0] deadband_q;
	logic [SpinW-1:0]     spin_goal_q;
	logic [StepLimW-1:0]  step_limit_q;
	logic [SpeedW-1:0]    scan_speed_q;
	logic [SpeedW-1:0]    track_speed_q;

	mode_t                      mode_q;
	logic [HeadingW-1:0]        prev_heading_q;
	logic [SpinW-1:0]           spin_q;
	logic signed [SignalW-1:0]  best_q;
	logic [HeadingW-1:0]        goal_q;

	logic                       valid_s1;
	logic [HeadingW-1:0]        heading_s1;
	logic signed [SignalW-1:0]  signal_s1;
	logic                       valid_s2;
	logic [OutFieldsW-1:0]      result_s2;

	logic                       advance;
	logic [HeadingW-1:0]        step;
	logic [HeadingW-1:0]        err_raw;
	logic signed [ErrW-1:0]     err_track;
	logic signed [ErrW-1:0]     db_s;
	logic [10:0]                spin_sum;
	logic [SpinW-1:0]           spin_acc;
	logic                       take_best;

	mode_t                      mode_d;
	logic [SpinW-1:0]           spin_d;
	logic signed [SignalW-1:0]  best_d;
	logic [HeadingW-1:0]        goal_d;
	logic [CmdW-1:0]            cmd_d;
	logic [SpeedW-1:0]          speed_d;
	logic signed [ErrW-1:0]     err_d;
	logic [PhaseW-1:0]          phase_d;

	assign advance   = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = {{(OutTdataW - OutFieldsW){1'b0}}, result_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q    <= DEADBAND_RST;
			spin_goal_q   <= SPIN_GOAL_RST;
			step_limit_q  <= STEP_LIMIT_RST;
			scan_speed_q  <= SCAN_SPEED_RST;
			track_speed_q <= TRACK_SPEED_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEADBAND:    deadband_q    <= cfg_data[DeadbandW-1:0];
				REG_SPIN_GOAL:   spin_goal_q   <= cfg_data[SpinW-1:0];
				REG_STEP_LIMIT:  step_limit_q  <= cfg_data[StepLimW-1:0];
				REG_SCAN_SPEED:  scan_speed_q  <= cfg_data[SpeedW-1:0];
				REG_TRACK_SPEED: track_speed_q <= cfg_data[SpeedW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		step      = wrap360(11'({2'b00, prev_heading_q}) + 11'd720 - 11'({2'b00, heading_s1}));
		err_raw   = wrap360(11'({2'b00, goal_q}) + 11'd540 - 11'({2'b00, heading_s1}));
		err_track = $signed(err_raw - 9'd180);
		db_s      = $signed({2'b00, deadband_q});
		spin_sum  = {1'b0, spin_q} + {2'b00, step};
		spin_acc  = spin_sum[10] ? SPIN_MAX : spin_sum[SpinW-1:0];
		take_best = signal_s1 >= best_q;

		mode_d  = mode_q;
		spin_d  = spin_q;
		best_d  = best_q;
		goal_d  = goal_q;
		err_d   = '0;
		cmd_d   = CMD_STOP;
		speed_d = '0;
		unique case (mode_q)
			MODE_START: begin
				spin_d = '0;
				mode_d = (spin_goal_q == '0) ? MODE_TRACK : MODE_SCAN;
			end
			MODE_SCAN: begin
				cmd_d   = CMD_LEFT;
				speed_d = scan_speed_q;
				if (take_best) begin
					best_d = signal_s1;
					goal_d = heading_s1;
				end
				if (step != '0 && step < {1'b0, step_limit_q}) begin
					spin_d = spin_acc;
				end
				if (spin_d >= spin_goal_q) begin
					mode_d = MODE_TRACK;
				end
			end
			default: begin
				err_d   = err_track;
				speed_d = track_speed_q;
				if (err_track > db_s) begin
					cmd_d = CMD_RIGHT;
				end else if (err_track < -db_s) begin
					cmd_d = CMD_LEFT;
				end else begin
					cmd_d = CMD_FORWARD;
				end
				if (take_best) begin
					best_d = signal_s1;
					goal_d = heading_s1;
				end
			end
		endcase

		unique case (mode_d)
			MODE_START: phase_d = PHASE_START;
			MODE_SCAN:  phase_d = PHASE_SCAN;
			default:    phase_d = PHASE_TRACK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			heading_s1 <= s_tdata[HeadingW-1:0];
			signal_s1  <= $signed(s_tdata[InFieldsW-1:HeadingW]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			mode_q         <= MODE_START;
			prev_heading_q <= '0;
			spin_q         <= '0;
			best_q         <= BEST_RST;
			goal_q         <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				mode_q         <= mode_d;
				prev_heading_q <= heading_s1;
				spin_q         <= spin_d;
				best_q         <= best_d;
				goal_q         <= goal_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= {phase_d, spin_d, goal_d, best_d, err_d, speed_d, cmd_d};
		end
	end

endmodule

`default_nettype wire

>>> design/sshs_checker.sv
`default_nettype none

`include "signal_seeking_heading_steer_defines.svh"

module sshs_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [sshs_pkg::InTdataW-1:0]   s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [sshs_pkg::OutTdataW-1:0]  m_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [sshs_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [sshs_pkg::CfgDataW-1:0]   cfg_data
);
	import sshs_pkg::*;

	logic [CmdW-1:0]     cmd;
	logic [SpeedW-1:0]   speed;
	logic [ErrW-1:0]     err;
	logic [SpinW-1:0]    spin;
	logic [PhaseW-1:0]   phase;
	logic                unused_in;

	assign cmd   = m_tdata[OfsSpeed-1:OfsCmd];
	assign speed = m_tdata[OfsErr-1:OfsSpeed];
	assign err   = m_tdata[OfsBest-1:OfsErr];
	assign spin  = m_tdata[OfsPhase-1:OfsSpin];
	assign phase = m_tdata[OfsPhase+PhaseW-1:OfsPhase];
	assign unused_in = ^{s_tvalid, s_tready, s_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

	`SSHS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))
	`SSHS_ASSERT_NOW(a_phase_started, clk, arst_n, m_tvalid, phase != PHASE_START)
	`SSHS_ASSERT_NOW(a_stop_clean, clk, arst_n, m_tvalid && cmd == CMD_STOP,
		speed == '0 && err == '0 && spin == '0)
	`SSHS_ASSERT_NOW(a_err_track, clk, arst_n, m_tvalid && err != '0,
		phase == PHASE_TRACK && cmd != CMD_STOP)

endmodule

bind signal_seeking_heading_steer sshs_checker u_sshs_checker (.*);

`default_nettype wire
